/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the quoted escape decoder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define QED_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define QED_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

/* rtl/qed_pkg.sv */
// Package for the quoted escape decoder: types, codes, character constants
// and the hex digit helper. No dependencies.
package qed_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int OUT_COUNT_BITS = 32;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NO_QUOTE     = 4'd0,
        ERR_OPEN_ESCAPE  = 4'd1,
        ERR_TRUNC_HEX    = 4'd2,
        ERR_BAD_HEX      = 4'd3,
        ERR_NONCANONICAL = 4'd4,
        ERR_UNKNOWN_ESC  = 4'd5,
        ERR_RAW_CONTROL  = 4'd6,
        ERR_UNTERMINATED = 4'd7,
        ERR_TOO_LONG     = 4'd8
    } t_err;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_source;
    } t_item;

    typedef struct packed {
        t_kind                      kind;
        logic [7:0]                 data_byte;
        logic [3:0]                 error_code;
        logic [OUT_COUNT_BITS-1:0]  byte_count;
    } t_result;

    // {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* rtl/qed_if.sv */
// Valid/ready channel interfaces of the quoted escape decoder: source bytes
// in, results out. Depends on nothing.
interface qed_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_source;

    modport source (output valid, output src_byte, output end_of_source, input ready);
    modport sink   (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface qed_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  error_code;
    logic [31:0] byte_count;

    modport source (output valid, output kind, output data_byte, output error_code,
                    output byte_count, input ready);
    modport sink   (input valid, input kind, input data_byte, input error_code,
                    input byte_count, output ready);
endinterface

/* rtl/qed_in_reg.sv */
// Input register of the quoted escape decoder: holds one accepted source item.
// Depends on qed_pkg and qed_src_if.
module qed_in_reg
    import qed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    qed_src_if.sink   i_src,
    input  logic      i_advance,
    output logic      o_valid,
    output t_item     o_item
);

    logic  r_valid;
    t_item r_item;

    assign i_src.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_src.valid && i_src.ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_item.src_byte      <= i_src.src_byte;
            r_item.end_of_source <= i_src.end_of_source;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/qed_decode.sv */
// Decode step of the quoted escape decoder: phase machine, hex nibble, byte
// counter and the NUL-escape enable register. Depends on qed_pkg.
module qed_decode
    import qed_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase                r_phase, n_phase;
    logic [3:0]            r_nib, n_nib;
    logic                  r_nib_ok, n_nib_ok;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_nul_en;

    logic [7:0]            c;
    logic                  eos;
    logic [4:0]            hex;
    logic [7:0]            hex_val;
    logic                  do_append;
    logic [7:0]            app_val;
    logic                  do_fail;
    t_err                  fail_code;
    logic [COUNT_BITS-1:0] cnt_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nul_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_nul_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_nib    <= '0;
            r_nib_ok <= 1'b0;
            r_cnt    <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_nib    <= n_nib;
            r_nib_ok <= n_nib_ok;
            r_cnt    <= n_cnt;
        end
    end

    assign c       = i_item.src_byte;
    assign eos     = i_item.end_of_source;
    assign hex     = hex_nibble(c);
    assign hex_val = {r_nib, hex[3:0]};

    always_comb begin
        n_phase            = r_phase;
        n_nib              = r_nib;
        n_nib_ok           = r_nib_ok;
        n_cnt              = r_cnt;
        do_append          = 1'b0;
        app_val            = c;
        do_fail            = 1'b0;
        fail_code          = ERR_NO_QUOTE;
        cnt_out            = r_cnt;
        o_result.kind      = KIND_NONE;
        o_result.data_byte = '0;
        o_result.error_code = '0;

        case (r_phase)
            PH_BODY: begin
                if (eos) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_UNTERMINATED;
                end else if (c == CH_QUOTE) begin
                    o_result.kind = KIND_DONE;
                    n_phase       = PH_IDLE;
                    n_cnt         = '0;
                end else if (c == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else if (c < CTRL_LIMIT || c == CH_DEL) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_RAW_CONTROL;
                end else begin
                    do_append = 1'b1;
                end
            end
            PH_ESC: begin
                if (eos) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_OPEN_ESCAPE;
                end else if (c == CH_BSLASH || c == CH_QUOTE) begin
                    do_append = 1'b1;
                end else if (c == CH_LOWER_N) begin
                    do_append = 1'b1;
                    app_val   = CH_LF;
                end else if (c == CH_LOWER_R) begin
                    do_append = 1'b1;
                    app_val   = CH_CR;
                end else if (c == CH_LOWER_T) begin
                    do_append = 1'b1;
                    app_val   = CH_TAB;
                end else if (c == CH_LOWER_X) begin
                    n_phase = PH_HEX1;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_UNKNOWN_ESC;
                end
            end
            PH_HEX1: begin
                if (eos) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNC_HEX;
                end else begin
                    n_nib_ok = hex[4];
                    n_nib    = hex[4] ? hex[3:0] : 4'h0;
                    n_phase  = PH_HEX2;
                end
            end
            PH_HEX2: begin
                if (eos) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNC_HEX;
                end else if (!r_nib_ok || !hex[4]) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_HEX;
                end else if ((hex_val >= CTRL_LIMIT && hex_val != CH_DEL) ||
                             (hex_val == 8'h00 && !r_nul_en)) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NONCANONICAL;
                end else begin
                    do_append = 1'b1;
                    app_val   = hex_val;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (eos) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_QUOTE;
                end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                    n_phase = PH_IDLE;
                end else if (c == CH_QUOTE) begin
                    n_cnt   = '0;
                    n_phase = PH_BODY;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_QUOTE;
                end
            end
        endcase

        // counter full: the byte is dropped and the literal fails
        if (do_append) begin
            if (r_cnt == {COUNT_BITS{1'b1}}) begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_LONG;
            end else begin
                n_cnt              = r_cnt + 1'b1;
                n_phase            = PH_BODY;
                cnt_out            = r_cnt + 1'b1;
                o_result.kind      = KIND_BYTE;
                o_result.data_byte = app_val;
            end
        end

        if (do_fail) begin
            o_result.kind       = KIND_ERROR;
            o_result.data_byte  = '0;
            o_result.error_code = fail_code;
            cnt_out             = r_cnt;
            n_phase             = PH_IDLE;
            n_cnt               = '0;
        end

        o_result.byte_count = OUT_COUNT_BITS'(cnt_out);
    end

endmodule

/* rtl/qed_out_reg.sv */
// Result register of the quoted escape decoder: holds one result until the
// sink takes it. Depends on qed_pkg and qed_res_if.
module qed_out_reg
    import qed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_can_load,
    qed_res_if.source  o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.kind       = r_res.kind;
    assign o_res.data_byte  = r_res.data_byte;
    assign o_res.error_code = r_res.error_code;
    assign o_res.byte_count = r_res.byte_count;

endmodule

/* rtl/quoted_escape_decoder.sv */
// Quoted escape decoder, top level: input register, decode step, result
// register. Depends on qed_pkg, qed_if, qed_in_reg, qed_decode, qed_out_reg.
//
// Decodes a C-style quoted literal one source byte per transfer and gives
// exactly one result per byte (nothing, decoded byte, literal complete or
// error). Throughput is one byte per cycle while the result is not stalled;
// each result is formed by the single decode step between the input
// register and the result register. A stalled result holds the input
// register, and the input stalls only while both are full. The NUL-escape
// enable is to be written through i_cfg_we / i_cfg_wdata only while no
// literal is in flight; the block does not enforce this. COUNT_BITS sets
// the width of the internal byte counter; byte_count shows its low 32 bits.
module quoted_escape_decoder
    import qed_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    qed_src_if.sink   i_src,
    qed_res_if.source o_res
);

    logic    in_valid;
    t_item   in_item;
    logic    out_can_load;
    logic    advance;
    t_result result;

    assign advance = in_valid && out_can_load;

    qed_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_src     (i_src),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    qed_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_item      (in_item),
        .o_result    (result)
    );

    qed_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (result),
        .o_can_load (out_can_load),
        .o_res      (o_res)
    );

endmodule

/* rtl/qed_checker.sv */
// Port-level checker for the quoted escape decoder, bound to the top level.
// Depends on qed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qed_checker
    import qed_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_src_valid,
    input logic        i_src_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_res_kind,
    input logic [7:0]  i_res_data_byte,
    input logic [3:0]  i_res_error_code,
    input logic [31:0] i_res_byte_count
);

    logic        in_xfer;
    logic        out_xfer;
    logic [1:0]  r_pend;
    logic        side_clean;
    logic        res_stall;
    logic [45:0] res_word;

    assign in_xfer  = i_src_valid && i_src_ready;
    assign out_xfer = i_res_valid && i_res_ready;

    // unused fields stay zero outside their own kind
    assign side_clean = (i_res_kind == KIND_BYTE) ||
                        (i_res_data_byte == 8'h00 &&
                         (i_res_kind == KIND_ERROR || i_res_error_code == 4'h0));
    assign res_stall  = i_res_valid && !i_res_ready;
    assign res_word   = {i_res_kind, i_res_data_byte, i_res_error_code, i_res_byte_count};

    // transfers in flight: at most the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    `QED_ASSERT(a_pend_bound, i_clk, i_rst_n, r_pend != 2'd3)
    `QED_ASSERT(a_no_phantom, i_clk, i_rst_n, out_xfer |-> r_pend != 2'd0)
    `QED_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n) |-> !i_res_valid)
    `QED_ASSERT(a_fields_clean, i_clk, i_rst_n, i_res_valid |-> side_clean)
    `QED_ASSERT(a_stall_hold, i_clk, i_rst_n, res_stall |=> (i_res_valid && $stable(res_word)))

endmodule

bind quoted_escape_decoder qed_checker u_qed_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_src_valid      (i_src.valid),
    .i_src_ready      (i_src.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_kind       (o_res.kind),
    .i_res_data_byte  (o_res.data_byte),
    .i_res_error_code (o_res.error_code),
    .i_res_byte_count (o_res.byte_count)
);
